// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants, types and codes of the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int ITER_W = $clog2(VALUE_WIDTH);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_CARET = 8'h5e;

	typedef enum logic [2:0] {
		OP_DIGIT,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_XOR,
		OP_OTHER
	} op_t;

	typedef enum logic [2:0] {
		ST_DIGIT     = 3'd0,
		ST_OPDONE    = 3'd1,
		ST_IGNORED   = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_DIVZERO   = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EXEC,
		B_DIV,
		B_WRITE
	} bstate_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] digit;
		logic       restart;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression one ASCII symbol per transaction.
//
// Input channel (in_valid / in_stall): symbol and restart. Digits push their
// value, + - * / ^ pop two operands and push the result (^ is bitwise XOR),
// any other symbol is ignored. restart empties the stack before the symbol.
// Output channel (out_valid / out_stall): one transaction per input with the
// new top of stack (0 when empty), the depth and a status code.
// Decoded symbols wait in a two-entry queue in front of the execution unit.
// Digits, ignored symbols, underflow and overflow are answered straight from
// the queue head; + - * ^ read the second operand, execute and write back; /
// runs the divider in between. Digits go at one per cycle while out_stall is
// low; an operator holds the execution unit until its result is written back,
// and the divider retires one quotient bit per cycle.
// When out_stall is high the result holds in the output register; the
// execution unit stops before its next result and the queue then fills and
// raises in_stall. Reset empties the stack, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator
	import pse_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             symbol,
	input  wire logic                   restart,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [VALUE_WIDTH-1:0]      top_value,
	output logic [CNT_W-1:0]            depth_now,
	output logic [2:0]                  status
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	pse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.symbol   (symbol),
		.restart  (restart),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_cmd    (q_cmd)
	);

	pse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.top_value (top_value),
		.depth_now (depth_now),
		.status    (status)
	);

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (depth_now <= CNT_W'(STACK_DEPTH)))
		else $error("depth beyond stack size");

	a_digit_push: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DIGIT) |->
			(depth_now != '0 && top_value < VALUE_WIDTH'(10)))
		else $error("digit push result inconsistent");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_UNDERFLOW) |-> (depth_now < CNT_W'(2)))
		else $error("underflow reported with two or more entries");

endmodule

`default_nettype wire

// ===== hdl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front
// Accepts input symbols, decodes them into commands and buffers them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_front
	import pse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] symbol,
	input  wire logic       restart,
	output logic            q_valid,
	input  wire logic       q_pop,
	output cmd_t            q_cmd
);

	cmd_t              dec_cmd;
	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	always_comb begin
		dec_cmd.restart = restart;
		dec_cmd.digit   = 4'(symbol - CH_ZERO);
		if (symbol >= CH_ZERO && symbol <= CH_NINE) begin
			dec_cmd.op = OP_DIGIT;
		end else begin
			case (symbol)
				CH_PLUS:  dec_cmd.op = OP_ADD;
				CH_MINUS: dec_cmd.op = OP_SUB;
				CH_STAR:  dec_cmd.op = OP_MUL;
				CH_SLASH: dec_cmd.op = OP_DIV;
				CH_CARET: dec_cmd.op = OP_XOR;
				default:  dec_cmd.op = OP_OTHER;
			endcase
		end
	end

	assign in_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pse_div.sv =====
// ----------------------------------------------------------------------------
// pse_div
// Signed divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div
	import pse_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [VALUE_WIDTH-1:0] divisor,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      quotient
);

	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] den_q;
	logic [VALUE_WIDTH:0]   rem_q;
	logic                   neg_q;
	logic                   busy_q;
	logic                   done_q;
	logic [ITER_W-1:0]      iter_q;
	logic [VALUE_WIDTH:0]   rem_sh;
	logic                   fits;
	logic                   a_neg;
	logic                   b_neg;

	assign a_neg  = dividend[VALUE_WIDTH-1];
	assign b_neg  = divisor[VALUE_WIDTH-1];
	assign rem_sh = {rem_q[VALUE_WIDTH-1:0], quo_q[VALUE_WIDTH-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= a_neg ? (VALUE_WIDTH'(0) - dividend) : dividend;
			den_q <= b_neg ? (VALUE_WIDTH'(0) - divisor) : divisor;
			rem_q <= '0;
			neg_q <= a_neg ^ b_neg;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (VALUE_WIDTH'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// ===== hdl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back
// Executes queued commands on the value stack and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_back
	import pse_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire cmd_t                q_cmd,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [VALUE_WIDTH-1:0]   top_value,
	output logic [CNT_W-1:0]         depth_now,
	output logic [2:0]               status
);

	logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];

	bstate_t                state_q, state_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [VALUE_WIDTH-1:0] top_q, top_d;
	logic [VALUE_WIDTH-1:0] res_q, res_d;
	logic                   ok_q, ok_d;
	op_t                    op_q, op_d;
	logic [VALUE_WIDTH-1:0] rd_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_top_q;
	logic [CNT_W-1:0]       out_depth_q;
	status_t                out_status_q;

	logic                   out_free;
	logic                   out_load;
	logic [VALUE_WIDTH-1:0] out_top_d;
	logic [CNT_W-1:0]       out_depth_d;
	status_t                out_status_d;

	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_wa;
	logic [VALUE_WIDTH-1:0] mem_wd;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_ra;
	logic [CNT_W-1:0]       cnt_eff;
	logic [CNT_W-1:0]       cnt_m2;
	logic [VALUE_WIDTH-1:0] digit_val;

	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo;

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_q),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_eff   = q_cmd.restart ? '0 : count_q;
	assign cnt_m2    = cnt_eff - CNT_W'(2);
	assign digit_val = VALUE_WIDTH'(q_cmd.digit);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		top_d        = top_q;
		res_d        = res_q;
		ok_d         = ok_q;
		op_d         = op_q;
		q_pop        = 1'b0;
		out_load     = 1'b0;
		out_top_d    = out_top_q;
		out_depth_d  = out_depth_q;
		out_status_d = out_status_q;
		mem_we       = 1'b0;
		mem_wa       = count_q[ADDR_W-1:0];
		mem_wd       = res_q;
		mem_re       = 1'b0;
		mem_ra       = cnt_m2[ADDR_W-1:0];
		div_start    = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid && out_free) begin
					q_pop       = 1'b1;
					count_d     = cnt_eff;
					out_load    = 1'b1;
					out_depth_d = cnt_eff;
					out_top_d   = (cnt_eff == '0) ? '0 : top_q;
					case (q_cmd.op)
						OP_DIGIT: begin
							if (cnt_eff == CNT_W'(STACK_DEPTH)) begin
								out_status_d = ST_OVERFLOW;
							end else begin
								mem_we       = 1'b1;
								mem_wa       = cnt_eff[ADDR_W-1:0];
								mem_wd       = digit_val;
								count_d      = cnt_eff + 1'b1;
								top_d        = digit_val;
								out_top_d    = digit_val;
								out_depth_d  = cnt_eff + 1'b1;
								out_status_d = ST_DIGIT;
							end
						end
						OP_OTHER: begin
							out_status_d = ST_IGNORED;
						end
						default: begin
							if (cnt_eff < CNT_W'(2)) begin
								out_status_d = ST_UNDERFLOW;
							end else begin
								out_load = 1'b0;
								mem_re   = 1'b1;
								op_d     = q_cmd.op;
								state_d  = B_EXEC;
							end
						end
					endcase
				end
			end
			B_EXEC: begin
				ok_d    = 1'b1;
				state_d = B_WRITE;
				case (op_q)
					OP_ADD: res_d = rd_q + top_q;
					OP_SUB: res_d = rd_q - top_q;
					OP_MUL: res_d = VALUE_WIDTH'(rd_q * top_q);
					OP_XOR: res_d = rd_q ^ top_q;
					OP_DIV: begin
						if (top_q == '0) begin
							ok_d = 1'b0;
						end else begin
							div_start = 1'b1;
							state_d   = B_DIV;
						end
					end
					default: ok_d = 1'b0;
				endcase
			end
			B_DIV: begin
				if (div_done) begin
					res_d   = div_quo;
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
					if (ok_q) begin
						mem_we       = 1'b1;
						mem_wa       = ADDR_W'(count_q - CNT_W'(2));
						mem_wd       = res_q;
						top_d        = res_q;
						count_d      = count_q - 1'b1;
						out_top_d    = res_q;
						out_depth_d  = count_q - 1'b1;
						out_status_d = ST_OPDONE;
					end else begin
						out_top_d    = top_q;
						out_depth_d  = count_q;
						out_status_d = ST_DIVZERO;
					end
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= stack_mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		res_q <= res_d;
		ok_q  <= ok_d;
		op_q  <= op_d;
		if (out_load) begin
			out_top_q    <= out_top_d;
			out_depth_q  <= out_depth_d;
			out_status_q <= out_status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = out_top_q;
	assign depth_now = out_depth_q;
	assign status    = out_status_q;

endmodule

`default_nettype wire
